// File: src/assert_macros.svh
// Assertion macros used by the top level of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: src/u8d_pkg.sv
// Types, codes and value checks for the UTF-8 stream decoder.
package u8d_pkg;

	localparam int DATA_W   = 8;
	localparam int CP_W     = 31;
	localparam int LEN_W    = 3;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 3;
	localparam int MODE_W   = 2;

	localparam logic [MODE_W-1:0] MODE_RAW      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STRICT   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MODIFIED = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_TRUNC    = 3'd1,
		ST_BAD_LEAD = 3'd2,
		ST_BAD_CONT = 3'd3,
		ST_FORM     = 3'd4,
		ST_BMP      = 3'd5,
		ST_NUL      = 3'd6
	} u8d_status_t;

	typedef struct packed {
		logic [CP_W-1:0]  code_point;
		logic [LEN_W-1:0] seq_length;
		u8d_status_t      status;
		logic [POS_W-1:0] error_position;
	} u8d_result_t;

	function automatic logic [LEN_W-1:0] shortest_len(input logic [CP_W-1:0] v);
		logic [LEN_W-1:0] n;
		if (v < 31'h80)
			n = 3'd1;
		else if (v < 31'h800)
			n = 3'd2;
		else if (v < 31'h10000)
			n = 3'd3;
		else if (v < 31'h200000)
			n = 3'd4;
		else if (v < 31'h4000000)
			n = 3'd5;
		else
			n = 3'd6;
		return n;
	endfunction

	function automatic u8d_status_t check_value(input logic [CP_W-1:0] v,
			input logic [LEN_W-1:0] n, input logic [MODE_W-1:0] mode);
		logic [LEN_W-1:0] sl;
		u8d_status_t st;
		sl = shortest_len(v);
		unique case (mode)
			MODE_RAW: begin
				st = ST_OK;
			end
			MODE_MODIFIED: begin
				if (v >= 31'h10000)
					st = ST_BMP;
				else if (v == '0)
					st = (n == 3'd2) ? ST_OK : ((n == 3'd1) ? ST_NUL : ST_FORM);
				else
					st = (sl == n) ? ST_OK : ST_FORM;
			end
			default: begin
				// strict; surrogates and values past U+10FFFF are invalid
				if (v >= 31'h110000 || (v < 31'h10000 && v[15:11] == 5'b11011))
					st = ST_FORM;
				else
					st = (sl == n) ? ST_OK : ST_FORM;
			end
		endcase
		return st;
	endfunction

endpackage

// File: src/u8d_in_if.sv
// Byte channel into the decoder.
interface u8d_in_if;
	import u8d_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data_byte;
	logic              last_in_buffer;

	modport source (output valid, output data_byte, output last_in_buffer, input ready);
	modport sink (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

// File: src/u8d_out_if.sv
// Result channel out of the decoder.
interface u8d_out_if;
	import u8d_pkg::*;

	logic                valid;
	logic                ready;
	logic [CP_W-1:0]     code_point;
	logic [LEN_W-1:0]    seq_length;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    error_position;

	modport source (output valid, output code_point, output seq_length, output status,
		output error_position, input ready);
	modport sink (input valid, input code_point, input seq_length, input status,
		input error_position, output ready);
endinterface

// File: src/u8d_decode.sv
// Sequence state and per-byte decode logic.
module u8d_decode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [u8d_pkg::MODE_W-1:0] mode,
	input  logic                       step,
	input  logic [u8d_pkg::DATA_W-1:0] data_byte,
	input  logic                       last_in_buffer,
	output logic                       fire,
	output u8d_pkg::u8d_result_t       result
);
	import u8d_pkg::*;

	logic [CP_W-1:0]  part_q, part_d;
	logic [LEN_W-1:0] exp_q, exp_d;
	logic [LEN_W-1:0] seen_q, seen_d;
	logic [POS_W-1:0] bad_q, bad_d;
	logic             halted_q, halted_d;

	logic [CP_W-1:0]  acc;
	logic [LEN_W-1:0] seen_inc;
	logic [POS_W-1:0] pos_new;
	logic [LEN_W-1:0] lead_len;
	logic [CP_W-1:0]  lead_val;
	u8d_status_t      chk_lead, chk_acc;

	logic [CP_W-1:0]  f_cp;
	logic [LEN_W-1:0] f_len;
	u8d_status_t      f_st;
	logic [POS_W-1:0] f_pos;

	assign acc      = {part_q[CP_W-7:0], data_byte[5:0]};
	assign seen_inc = seen_q + 3'd1;
	assign pos_new  = (data_byte[7:6] != 2'b10 && bad_q == '0) ? seen_q : bad_q;
	assign chk_lead = check_value({{(CP_W-DATA_W){1'b0}}, data_byte}, 3'd1, mode);
	assign chk_acc  = check_value(acc, exp_q, mode);

	always_comb begin
		unique casez (data_byte)
			8'b110?????: begin
				lead_len = 3'd2;
				lead_val = {{(CP_W-5){1'b0}}, data_byte[4:0]};
			end
			8'b1110????: begin
				lead_len = 3'd3;
				lead_val = {{(CP_W-4){1'b0}}, data_byte[3:0]};
			end
			8'b11110???: begin
				lead_len = 3'd4;
				lead_val = {{(CP_W-3){1'b0}}, data_byte[2:0]};
			end
			8'b111110??: begin
				lead_len = 3'd5;
				lead_val = {{(CP_W-2){1'b0}}, data_byte[1:0]};
			end
			default: begin
				lead_len = 3'd6;
				lead_val = {{(CP_W-1){1'b0}}, data_byte[0]};
			end
		endcase
	end

	always_comb begin
		halted_d = halted_q;
		exp_d    = exp_q;
		seen_d   = seen_q;
		bad_d    = bad_q;
		part_d   = part_q;
		fire     = 1'b0;
		f_cp     = '0;
		f_len    = '0;
		f_st     = ST_OK;
		f_pos    = '0;
		if (halted_q) begin
			if (last_in_buffer) begin
				halted_d = 1'b0;
				exp_d    = '0;
				seen_d   = '0;
				bad_d    = '0;
				part_d   = '0;
			end
		end else if (exp_q == '0) begin
			if (!data_byte[7]) begin
				fire  = 1'b1;
				f_cp  = {{(CP_W-DATA_W){1'b0}}, data_byte};
				f_len = 3'd1;
				f_st  = chk_lead;
			end else if (data_byte[7:6] == 2'b10 || data_byte[7:1] == 7'h7F) begin
				fire = 1'b1;
				f_st = ST_BAD_LEAD;
			end else begin
				exp_d  = lead_len;
				part_d = lead_val;
				seen_d = 3'd1;
				bad_d  = '0;
				if (last_in_buffer) begin
					fire = 1'b1;
					f_st = ST_TRUNC;
				end
			end
		end else begin
			part_d = acc;
			seen_d = seen_inc;
			bad_d  = pos_new;
			if (seen_inc >= exp_q) begin
				fire = 1'b1;
				if (pos_new != '0) begin
					f_st  = ST_BAD_CONT;
					f_pos = pos_new;
				end else begin
					f_cp  = acc;
					f_len = exp_q;
					f_st  = chk_acc;
				end
			end else if (last_in_buffer) begin
				fire = 1'b1;
				f_st = ST_TRUNC;
			end
		end
		if (fire) begin
			exp_d  = '0;
			seen_d = '0;
			bad_d  = '0;
			part_d = '0;
			if (f_st != ST_OK && !last_in_buffer)
				halted_d = 1'b1;
		end
	end

	always_comb begin
		result.code_point     = (f_st == ST_OK) ? f_cp : '0;
		result.seq_length     = (f_st == ST_OK) ? f_len : '0;
		result.status         = f_st;
		result.error_position = f_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q   <= '0;
			exp_q    <= '0;
			seen_q   <= '0;
			bad_q    <= '0;
			halted_q <= 1'b0;
		end else if (step) begin
			part_q   <= part_d;
			exp_q    <= exp_d;
			seen_q   <= seen_d;
			bad_q    <= bad_d;
			halted_q <= halted_d;
		end
	end

endmodule

// File: src/utf8_stream_decoder_core.sv
// Top level of the streaming UTF-8 decoder.
//
// in_ch carries one byte per word with an end-of-buffer flag; out_ch carries
// one result word (code point, length, status, error position) per decoded
// sequence or error. Bytes inside a sequence and bytes discarded after an
// error give no result word.
// Both channels use valid/ready; a word moves when both are high.
// A result word is registered: the byte is captured in the input register,
// then decoded out of the input register into the result register. Throughput
// is one byte per cycle while out_ch does not stall.
// When out_ch stalls, the result register holds its word; the input register
// takes one more byte only if it is empty, then in_ch ready drops.
// cfg_wr_en/cfg_wr_data write the decode mode (0 raw, 1 strict, 2 modified);
// write it only while the block is idle.
// Reset clears the valid flags of both registers (not their data), the
// sequence state and the halt flag, and sets strict mode.
`include "assert_macros.svh"

module utf8_stream_decoder_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [u8d_pkg::MODE_W-1:0] cfg_wr_data,
	u8d_in_if.sink                     in_ch,
	u8d_out_if.source                  out_ch
);
	import u8d_pkg::*;

	logic [MODE_W-1:0] mode_q;
	logic              valid_s1;
	logic [DATA_W-1:0] byte_s1;
	logic              last_s1;
	logic              out_valid_q;
	u8d_result_t       out_res_q;
	logic              advance;
	logic              fire;
	u8d_result_t       result;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= MODE_STRICT;
		else if (cfg_wr_en)
			mode_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.valid && in_ch.ready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_in_buffer;
		end
	end

	u8d_decode u_decode (
		.clk            (clk),
		.arst_n         (arst_n),
		.mode           (mode_q),
		.step           (advance),
		.data_byte      (byte_s1),
		.last_in_buffer (last_s1),
		.fire           (fire),
		.result         (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && fire)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && fire)
			out_res_q <= result;
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.code_point     = out_res_q.code_point;
	assign out_ch.seq_length     = out_res_q.seq_length;
	assign out_ch.status         = out_res_q.status;
	assign out_ch.error_position = out_res_q.error_position;

	`ASSERT_IMPLIES(a_err_zeroed, clk, arst_n,
		out_valid_q && out_res_q.status != ST_OK,
		out_res_q.code_point == '0 && out_res_q.seq_length == '0)
	`ASSERT_IMPLIES(a_ok_has_len, clk, arst_n,
		out_valid_q && out_res_q.status == ST_OK, out_res_q.seq_length != '0)
	`ASSERT_IMPLIES(a_pos_only_cont, clk, arst_n,
		out_valid_q && out_res_q.error_position != '0, out_res_q.status == ST_BAD_CONT)
	`ASSERT_IMPLIES(a_full_stall, clk, arst_n,
		valid_s1 && out_valid_q && !out_ch.ready, !in_ch.ready)
	`ASSERT_NEXT(a_byte_held, clk, arst_n, in_ch.valid && in_ch.ready, valid_s1)

endmodule

// File: dv/u8d_checker.sv
// Decoder scoreboard: watches byte, result and mode-write words, predicts and compares.
module u8d_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [u8d_pkg::MODE_W-1:0] cfg_wr_data,
	u8d_in_if                          in_mon,
	u8d_out_if                         out_mon,
	output int                         fail_count,
	output int                         outstanding,
	output int                         live_bytes,
	output int                         words_seen,
	output logic [6:0]                 status_seen
);
	import u8d_pkg::*;

	u8d_result_t       expected_words[$];
	logic [MODE_W-1:0] cur_mode;
	logic [CP_W-1:0]   acc_value;
	logic [LEN_W-1:0]  seq_len;
	logic [LEN_W-1:0]  seen;
	logic [POS_W-1:0]  bad_at;
	logic              halted;
	int                errors;
	int                n_live;
	int                n_words;
	logic [6:0]        st_mask;

	function automatic logic [LEN_W-1:0] min_len(input logic [CP_W-1:0] v);
		if (v[30:26] != '0)
			return 3'd6;
		if (v[25:21] != '0)
			return 3'd5;
		if (v[20:16] != '0)
			return 3'd4;
		if (v[15:11] != '0)
			return 3'd3;
		if (v[10:7] != '0)
			return 3'd2;
		return 3'd1;
	endfunction

	function automatic u8d_status_t judge_value(input logic [CP_W-1:0] v,
			input logic [LEN_W-1:0] n);
		if (cur_mode == MODE_RAW)
			return ST_OK;
		if (cur_mode == MODE_MODIFIED) begin
			if (v[30:16] != '0)
				return ST_BMP;
			if (v == '0) begin
				if (n == 3'd2)
					return ST_OK;
				return (n == 3'd1) ? ST_NUL : ST_FORM;
			end
			return (min_len(v) == n) ? ST_OK : ST_FORM;
		end
		if (v > 31'h10FFFF)
			return ST_FORM;
		if (v[30:16] == '0 && v[15:11] == 5'b11011)
			return ST_FORM;
		return (min_len(v) == n) ? ST_OK : ST_FORM;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("MISMATCH word %0d %s: got %0h, expected %0h", n_words, what, got, want);
	endtask

	task automatic decode_byte(input logic [DATA_W-1:0] b, input logic last);
		u8d_result_t r;
		logic        emit;
		emit = 1'b0;
		r = '{code_point: '0, seq_length: '0, status: ST_OK, error_position: '0};
		if (halted) begin
			if (last) begin
				halted = 1'b0;
				acc_value = '0;
				seq_len = '0;
				seen = '0;
				bad_at = '0;
			end
			return;
		end
		n_live++;
		if (seq_len == '0) begin
			if (!b[7]) begin
				emit = 1'b1;
				r.code_point = CP_W'(b);
				r.seq_length = 3'd1;
				r.status = judge_value(CP_W'(b), 3'd1);
			end else if (b[7:6] == 2'b10 || b[7:1] == 7'h7F) begin
				emit = 1'b1;
				r.status = ST_BAD_LEAD;
			end else begin
				casez (b)
					8'b110?????: seq_len = 3'd2;
					8'b1110????: seq_len = 3'd3;
					8'b11110???: seq_len = 3'd4;
					8'b111110??: seq_len = 3'd5;
					default: seq_len = 3'd6;
				endcase
				acc_value = CP_W'(b & (8'hFF >> (seq_len + 1)));
				seen = 3'd1;
				bad_at = '0;
				if (last) begin
					emit = 1'b1;
					r.status = ST_TRUNC;
				end
			end
		end else begin
			if (b[7:6] != 2'b10 && bad_at == '0)
				bad_at = seen;
			acc_value = {acc_value[24:0], b[5:0]};
			seen = seen + 3'd1;
			if (seen >= seq_len) begin
				emit = 1'b1;
				if (bad_at != '0) begin
					r.status = ST_BAD_CONT;
					r.error_position = bad_at;
				end else begin
					r.code_point = acc_value;
					r.seq_length = seq_len;
					r.status = judge_value(acc_value, seq_len);
				end
			end else if (last) begin
				emit = 1'b1;
				r.status = ST_TRUNC;
			end
		end
		if (emit) begin
			if (r.status != ST_OK) begin
				r.code_point = '0;
				r.seq_length = '0;
				if (!last)
					halted = 1'b1;
			end
			acc_value = '0;
			seq_len = '0;
			seen = '0;
			bad_at = '0;
			expected_words.push_back(r);
			st_mask[r.status] = 1'b1;
		end
	endtask

	task automatic check_word();
		u8d_result_t want;
		n_words++;
		if (expected_words.size() == 0) begin
			report_mismatch("unexpected word, code point", 32'(out_mon.code_point), '0);
			return;
		end
		want = expected_words.pop_front();
		if (out_mon.code_point !== want.code_point)
			report_mismatch("code_point", 32'(out_mon.code_point), 32'(want.code_point));
		if (out_mon.seq_length !== want.seq_length)
			report_mismatch("seq_length", 32'(out_mon.seq_length), 32'(want.seq_length));
		if (out_mon.status !== want.status)
			report_mismatch("status", 32'(out_mon.status), 32'(want.status));
		if (out_mon.error_position !== want.error_position)
			report_mismatch("error_position", 32'(out_mon.error_position),
				32'(want.error_position));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_words.delete();
			cur_mode = MODE_STRICT;
			acc_value = '0;
			seq_len = '0;
			seen = '0;
			bad_at = '0;
			halted = 1'b0;
			errors = 0;
			n_live = 0;
			n_words = 0;
			st_mask = '0;
		end else begin
			if (out_mon.valid && out_mon.ready)
				check_word();
			if (in_mon.valid && in_mon.ready)
				decode_byte(in_mon.data_byte, in_mon.last_in_buffer);
			if (cfg_wr_en)
				cur_mode = cfg_wr_data;
		end
		fail_count <= errors;
		outstanding <= expected_words.size();
		live_bytes <= n_live;
		words_seen <= n_words;
		status_seen <= st_mask;
	end

endmodule

// File: dv/tb.sv
// Testbench top for the UTF-8 stream decoder: clock, reset, byte stimulus, mode writes and verdict.
module tb;
	import u8d_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [MODE_W-1:0] cfg_wr_data;
	int                src_idle;
	int                sink_idle;
	int                fail_count;
	int                outstanding;
	int                live_bytes;
	int                words_seen;
	logic [6:0]        status_seen;
	int                mode_writes;
	logic [7:0]        text_buf[$];

	u8d_in_if  byte_ch ();
	u8d_out_if word_ch ();

	utf8_stream_decoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (byte_ch),
		.out_ch      (word_ch)
	);

	u8d_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_mon      (byte_ch),
		.out_mon     (word_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.live_bytes  (live_bytes),
		.words_seen  (words_seen),
		.status_seen (status_seen)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial word_ch.ready = 1'b0;
	always @(posedge clk) begin
		word_ch.ready <= ($urandom_range(99) >= sink_idle);
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_in_buffer <= last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	// hold the sender until every predicted word is out, then cover the pipe depth
	task automatic wait_quiet();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mode_writes++;
	endtask

	// random buffer: mostly well-formed sequences, some overlong, corrupt, cut short or noise
	task automatic make_text();
		int          nseq;
		int          r;
		int          sz;
		int          cl;
		int          n;
		int          cut;
		logic [30:0] v;
		logic [30:0] lo;
		logic [30:0] hi;
		logic [30:0] w;
		logic [7:0]  enc[6];
		logic [7:0]  pre;
		logic [7:0]  msk;
		text_buf.delete();
		if ($urandom_range(99) < 8) begin
			sz = $urandom_range(8, 1);
			repeat (sz) text_buf.push_back(8'($urandom));
			return;
		end
		nseq = $urandom_range(6, 1);
		for (int s = 0; s < nseq; s++) begin
			r = $urandom_range(99);
			cl = (r < 30) ? 1 : (r < 55) ? 2 : (r < 75) ? 3 : (r < 90) ? 4 : (r < 95) ? 5 : 6;
			case (cl)
				1: begin
					lo = 31'h0;
					hi = 31'h7F;
				end
				2: begin
					lo = 31'h80;
					hi = 31'h7FF;
				end
				3: begin
					lo = 31'h800;
					hi = 31'hFFFF;
				end
				4: begin
					lo = 31'h10000;
					hi = 31'h1FFFFF;
				end
				5: begin
					lo = 31'h200000;
					hi = 31'h3FFFFFF;
				end
				default: begin
					lo = 31'h4000000;
					hi = 31'h7FFFFFFF;
				end
			endcase
			r = $urandom_range(99);
			if (r < 8)
				v = r[0] ? hi : lo;
			else if (r < 14 && cl == 3)
				v = 31'hD800 + 31'($urandom_range(31'h7FF));
			else if (r < 14 && cl == 4)
				v = r[0] ? 31'h10FFFF : 31'h110000;
			else
				v = 31'($urandom_range(hi, lo));
			n = cl;
			if (n < 6 && $urandom_range(9) == 0)
				n = $urandom_range(6, n + 1);
			w = v;
			for (int k = n - 1; k >= 1; k--) begin
				enc[k] = {2'b10, w[5:0]};
				w = w >> 6;
			end
			if (n == 1) begin
				enc[0] = {1'b0, w[6:0]};
			end else begin
				pre = 8'hFF << (8 - n);
				msk = 8'hFF >> (n + 1);
				enc[0] = pre | (w[7:0] & msk);
			end
			r = $urandom_range(99);
			if (r < 6 && n > 1)
				enc[$urandom_range(n - 1, 1)] = 8'($urandom);
			if (r >= 90)
				text_buf.push_back(8'($urandom));
			if (r >= 6 && r < 12 && n > 1) begin
				cut = $urandom_range(n - 1, 1);
				for (int k = 0; k < cut; k++)
					text_buf.push_back(enc[k]);
				break;
			end
			for (int k = 0; k < n; k++)
				text_buf.push_back(enc[k]);
		end
	endtask

	initial begin
		int                live_goal;
		int                chunk_end;
		logic [MODE_W-1:0] mode_pick[3];
		mode_pick = '{MODE_RAW, MODE_STRICT, MODE_MODIFIED};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = MODE_STRICT;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_in_buffer = 1'b0;
		src_idle = 15;
		sink_idle = 86;
		mode_writes = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// strict mode out of reset
		text_buf = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
		send_text();
		text_buf = '{8'hED, 8'hA0, 8'h80};
		send_text();
		text_buf = '{8'hFF, 8'h41};
		send_text();
		text_buf = '{8'hE2, 8'h28, 8'hA1};
		send_text();
		text_buf = '{8'hF0, 8'h90};
		send_text();
		wait_quiet();
		set_mode(MODE_MODIFIED);
		text_buf = '{8'hC0, 8'h80, 8'h00};
		send_text();
		wait_quiet();
		set_mode(MODE_RAW);
		text_buf = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
		send_text();
		text_buf = '{8'hFE};
		send_text();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					src_idle = 15;
					sink_idle = 86;
				end
				1: begin
					src_idle = 86;
					sink_idle = 15;
				end
				default: begin
					src_idle = 0;
					sink_idle = 0;
				end
			endcase
			live_goal = live_bytes + 534;
			while (live_bytes < live_goal) begin
				wait_quiet();
				set_mode(mode_pick[$urandom_range(2)]);
				chunk_end = live_bytes + $urandom_range(120, 40);
				while (live_bytes < chunk_end && live_bytes < live_goal) begin
					make_text();
					send_text();
				end
			end
		end

		wait_quiet();
		repeat (8) @(posedge clk);
		$display("Run covered %0d decoded bytes and %0d result words over %0d mode writes",
			live_bytes, words_seen, mode_writes);
		$display("Status codes seen (bit per code, ok at bit 0): %b", status_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#1600000;
		$display("Some tests failed");
		$finish;
	end

endmodule
